FILE: sv/ddap_pkg.sv
// ----------------------------------------------------------------------------
// ddap_pkg: shared definitions for the dense shortest-path unit
// Field widths, reset values, request kinds, register indexes and states.
// ----------------------------------------------------------------------------
package ddap_pkg;

    // Fixed field widths of the request and result channels.
    localparam int NODE_FIELD_W   = 6;
    localparam int WEIGHT_FIELD_W = 16;
    localparam int DIST_W         = 22;
    localparam int PRED_FIELD_W   = 64;
    localparam int KIND_W         = 2;
    localparam int NODE_COUNT_W   = 7;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 7;

    // Saturation value of path sums.
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Parameter defaults.
    localparam int MAX_NODES_DEF   = 64;
    localparam int WEIGHT_BITS_DEF = 16;

    // Configuration register reset values.
    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RST = 7'd64;
    localparam logic [NODE_FIELD_W-1:0] SOURCE_RST     = 6'd0;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NODE_COUNT = 2'd0,
        CFG_SOURCE     = 2'd1
    } t_cfg_index;

    // Request kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_RUN   = 2'd2
    } t_kind;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD2,
        ST_INIT,
        ST_SEL,
        ST_RELAX,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

endpackage

FILE: sv/ddap_if.sv
// ----------------------------------------------------------------------------
// ddap_if: channel interfaces of the dense shortest-path unit
// Request, result and configuration write channels with valid and ready.
// ----------------------------------------------------------------------------
interface ddap_in_if;
    logic                                valid;
    logic                                ready;
    logic [ddap_pkg::KIND_W-1:0]         kind;
    logic [ddap_pkg::NODE_FIELD_W-1:0]   node_a;
    logic [ddap_pkg::NODE_FIELD_W-1:0]   node_b;
    logic [ddap_pkg::WEIGHT_FIELD_W-1:0] weight;

    modport source (output valid, kind, node_a, node_b, weight, input ready);
    modport sink (input valid, kind, node_a, node_b, weight, output ready);
endinterface

interface ddap_out_if;
    logic                              valid;
    logic                              ready;
    logic [ddap_pkg::NODE_FIELD_W-1:0] node;
    logic [ddap_pkg::DIST_W-1:0]       distance;
    logic                              reachable;
    logic [ddap_pkg::PRED_FIELD_W-1:0] predecessors;
    logic                              last;

    modport source (output valid, node, distance, reachable, predecessors, last,
                    input ready);
    modport sink (input valid, node, distance, reachable, predecessors, last,
                  output ready);
endinterface

interface ddap_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ddap_pkg::CFG_INDEX_W-1:0] index;
    logic [ddap_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/dense_dijkstra_all_predecessors_unit.sv
// ----------------------------------------------------------------------------
// dense_dijkstra_all_predecessors_unit: dense shortest paths with predecessors
// Sequencer over an adjacency memory and one shared add and compare unit.
// ----------------------------------------------------------------------------
// Usage: requests enter on i_in. A load writes one weight into both directions
// of the adjacency store, the mirror entry in ST_LOAD2. A clear sweeps the store,
// one entry a cycle. A run finds distances from source_node and emits one
// result per node on o_out, in index order, last set on the final node.
// The user must write node_count and source_node on i_cfg only while the
// unit is idle; the unit itself does not enforce this. Each selection pass
// reads the distance memory once per node, and each relaxation pass reads
// one adjacency row, both at one node per cycle through registered reads.
// The unit accepts no request while it works. After reset it runs a clearing
// pass over the adjacency store before i_in becomes ready. If the receiver
// stalls, the held result waits in the output register and the run pauses
// until it is taken.
// ----------------------------------------------------------------------------
module dense_dijkstra_all_predecessors_unit #(
    parameter int MAX_NODES   = ddap_pkg::MAX_NODES_DEF,
    parameter int WEIGHT_BITS = ddap_pkg::WEIGHT_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ddap_in_if.sink      i_in,
    ddap_out_if.source   o_out,
    ddap_cfg_if.sink     i_cfg
);

    localparam int NB  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int AW  = 2 * NB;
    localparam int DW  = ddap_pkg::DIST_W;
    localparam int WB  = WEIGHT_BITS;
    localparam int NFW = ddap_pkg::NODE_FIELD_W;
    localparam int PFW = ddap_pkg::PRED_FIELD_W;
    localparam int WFW = ddap_pkg::WEIGHT_FIELD_W;
    localparam int NCW = ddap_pkg::NODE_COUNT_W;

    // Sequencer and control registers.
    ddap_pkg::t_state r_state, n_state;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_pv, n_pv;
    logic [NB-1:0]        r_pi, n_pi;
    logic                 r_found, n_found;
    logic [DW-1:0]        r_best, n_best;
    logic [NB-1:0]        r_k, n_k;
    logic [MAX_NODES-1:0] r_visited, n_visited;
    logic [MAX_NODES-1:0] r_reached, n_reached;
    logic [CW-1:0]        r_n, n_n;
    logic [NB-1:0]        r_a, n_a;
    logic [NB-1:0]        r_b, n_b;
    logic [WFW-1:0]       r_w, n_w;
    logic [AW-1:0]        r_clr, n_clr;
    logic [NCW-1:0]       r_node_count;
    logic [NFW-1:0]       r_source;

    // Output register.
    logic                 r_ovalid, n_ovalid;
    logic [NB-1:0]        r_onode, n_onode;
    logic [DW-1:0]        r_odist, n_odist;
    logic                 r_oreach, n_oreach;
    logic [MAX_NODES-1:0] r_opred, n_opred;
    logic                 r_olast, n_olast;

    // Node memories.
    logic [DW-1:0]        dist_mem [MAX_NODES];
    logic [MAX_NODES-1:0] pred_mem [MAX_NODES];
    logic [DW-1:0]        r_dist_q;
    logic [MAX_NODES-1:0] r_pred_q;
    logic                 mem_we;
    logic [NB-1:0]        mem_wr_idx;
    logic [NB-1:0]        mem_rd_idx;
    logic [DW-1:0]        mem_wr_dist;
    logic [MAX_NODES-1:0] mem_wr_pred;

    // Adjacency port and shared unit signals.
    logic                 adj_we;
    logic [AW-1:0]        adj_waddr;
    logic [WB:0]          adj_wdata;
    logic [AW-1:0]        adj_raddr;
    logic [WB:0]          adj_rdata;
    logic [DW-1:0]        alu_base;
    logic [WB-1:0]        alu_add;
    logic [DW-1:0]        alu_cmp;
    logic [DW-1:0]        alu_sum;
    logic                 alu_lt;
    logic                 alu_eq;

    // Helper values.
    logic [NB-1:0]        idx;
    logic [WB+WFW-1:0]    in_wext;
    logic [WB+WFW-1:0]    r_wext;
    logic [MAX_NODES-1:0] k_hot;
    logic [NCW-1:0]       eff_n;
    logic                 pi_last;
    logic                 take;
    logic                 sel_found;
    logic [NB-1:0]        sel_k;
    logic [NFW+NB-1:0]    onode_ext;
    logic [PFW+MAX_NODES-1:0] opred_ext;

    assign idx     = r_cnt[NB-1:0];
    assign in_wext = {{WB{1'b0}}, i_in.weight};
    assign r_wext  = {{WB{1'b0}}, r_w};
    assign k_hot   = {{(MAX_NODES-1){1'b0}}, 1'b1} << r_k;
    assign pi_last = CW'(r_pi) == CW'(r_n - 1'b1);

    // Effective node count, clamped to the range in use.
    always_comb begin
        if (r_node_count == '0) begin
            eff_n = NCW'(1);
        end else if (r_node_count > NCW'(MAX_NODES)) begin
            eff_n = NCW'(MAX_NODES);
        end else begin
            eff_n = r_node_count;
        end
    end

    ddap_adj_ram #(
        .AW (AW),
        .DW (WB + 1)
    ) u_adj (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    ddap_alu #(
        .WB (WB)
    ) u_alu (
        .i_base   (alu_base),
        .i_addend (alu_add),
        .i_cmp    (alu_cmp),
        .o_sum    (alu_sum),
        .o_lt     (alu_lt),
        .o_eq     (alu_eq)
    );

    // Next state, memory control and shared unit operands.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pv        = 1'b0;
        n_pi        = r_pi;
        n_found     = r_found;
        n_best      = r_best;
        n_k         = r_k;
        n_visited   = r_visited;
        n_reached   = r_reached;
        n_n         = r_n;
        n_a         = r_a;
        n_b         = r_b;
        n_w         = r_w;
        n_clr       = r_clr;
        n_ovalid    = r_ovalid && !o_out.ready;
        n_onode     = r_onode;
        n_odist     = r_odist;
        n_oreach    = r_oreach;
        n_opred     = r_opred;
        n_olast     = r_olast;
        i_in.ready  = 1'b0;
        mem_we      = 1'b0;
        mem_wr_idx  = r_pi;
        mem_rd_idx  = idx;
        mem_wr_dist = alu_sum;
        mem_wr_pred = k_hot;
        adj_we      = 1'b0;
        adj_waddr   = {r_a, r_b};
        adj_wdata   = {1'b1, r_wext[WB-1:0]};
        adj_raddr   = {r_k, idx};
        alu_base    = r_dist_q;
        alu_add     = '0;
        alu_cmp     = r_best;
        take        = 1'b0;
        sel_found   = r_found;
        sel_k       = r_k;

        unique case (r_state)
            ddap_pkg::ST_CLEAR: begin
                adj_we    = 1'b1;
                adj_waddr = r_clr;
                adj_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = ddap_pkg::ST_IDLE;
                end
            end
            ddap_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    unique case (i_in.kind)
                        ddap_pkg::KIND_LOAD: begin
                            if ((7'(i_in.node_a) < 7'(MAX_NODES))
                                    && (7'(i_in.node_b) < 7'(MAX_NODES))) begin
                                adj_we    = 1'b1;
                                adj_waddr = {i_in.node_a[NB-1:0], i_in.node_b[NB-1:0]};
                                adj_wdata = {1'b1, in_wext[WB-1:0]};
                                n_a       = i_in.node_b[NB-1:0];
                                n_b       = i_in.node_a[NB-1:0];
                                n_w       = i_in.weight;
                                n_state   = ddap_pkg::ST_LOAD2;
                            end
                        end
                        ddap_pkg::KIND_CLEAR: begin
                            n_clr   = '0;
                            n_state = ddap_pkg::ST_CLEAR;
                        end
                        ddap_pkg::KIND_RUN: begin
                            n_n     = eff_n[CW-1:0];
                            n_state = ddap_pkg::ST_INIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ddap_pkg::ST_LOAD2: begin
                // Mirror entry of the edge.
                adj_we  = 1'b1;
                n_state = ddap_pkg::ST_IDLE;
            end
            ddap_pkg::ST_INIT: begin
                n_visited = '0;
                n_reached = '0;
                n_cnt     = '0;
                n_found   = 1'b0;
                if ((CW + 1)'(r_source) < (CW + 1)'(r_n)) begin
                    n_reached[r_source[NB-1:0]] = 1'b1;
                    mem_we      = 1'b1;
                    mem_wr_idx  = r_source[NB-1:0];
                    mem_wr_dist = '0;
                    mem_wr_pred = '0;
                    n_state     = ddap_pkg::ST_SEL;
                end else begin
                    n_state = ddap_pkg::ST_EMIT_RD;
                end
            end
            ddap_pkg::ST_SEL: begin
                // Stream distances and keep the strictly smallest open node.
                if (r_cnt < r_n) begin
                    n_cnt = r_cnt + 1'b1;
                    n_pv  = 1'b1;
                    n_pi  = idx;
                end
                if (r_pv) begin
                    take = !r_visited[r_pi] && r_reached[r_pi] && (!r_found || alu_lt);
                    if (take) begin
                        sel_found = 1'b1;
                        sel_k     = r_pi;
                        n_found   = 1'b1;
                        n_best    = r_dist_q;
                        n_k       = r_pi;
                    end
                    if (pi_last) begin
                        n_cnt = '0;
                        n_pv  = 1'b0;
                        if (sel_found) begin
                            n_visited[sel_k] = 1'b1;
                            n_state = ddap_pkg::ST_RELAX;
                        end else begin
                            n_state = ddap_pkg::ST_EMIT_RD;
                        end
                    end
                end
            end
            ddap_pkg::ST_RELAX: begin
                // Walk the row of the chosen node and relax each neighbor.
                if (r_cnt < r_n) begin
                    n_cnt = r_cnt + 1'b1;
                    n_pv  = 1'b1;
                    n_pi  = idx;
                end
                alu_base = r_best;
                alu_add  = adj_rdata[WB-1:0];
                alu_cmp  = r_dist_q;
                if (r_pv) begin
                    if (!r_visited[r_pi] && adj_rdata[WB]) begin
                        if (!r_reached[r_pi] || alu_lt) begin
                            mem_we = 1'b1;
                            n_reached[r_pi] = 1'b1;
                        end else if (alu_eq) begin
                            mem_we      = 1'b1;
                            mem_wr_dist = r_dist_q;
                            mem_wr_pred = r_pred_q | k_hot;
                        end
                    end
                    if (pi_last) begin
                        n_cnt   = '0;
                        n_pv    = 1'b0;
                        n_found = 1'b0;
                        n_state = ddap_pkg::ST_SEL;
                    end
                end
            end
            ddap_pkg::ST_EMIT_RD: begin
                n_state = ddap_pkg::ST_EMIT_LD;
            end
            ddap_pkg::ST_EMIT_LD: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_onode  = idx;
                    n_oreach = r_reached[idx];
                    n_odist  = r_reached[idx] ? r_dist_q : '0;
                    n_opred  = r_reached[idx] ? r_pred_q : '0;
                    n_olast  = r_cnt == CW'(r_n - 1'b1);
                    if (r_cnt == CW'(r_n - 1'b1)) begin
                        n_state = ddap_pkg::ST_IDLE;
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        n_state = ddap_pkg::ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ddap_pkg::ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddap_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_ovalid  <= 1'b0;
            r_visited <= '0;
            r_reached <= '0;
            r_pv      <= 1'b0;
            r_cnt     <= '0;
            r_found   <= 1'b0;
        end else begin
            r_clr     <= n_clr;
            r_ovalid  <= n_ovalid;
            r_visited <= n_visited;
            r_reached <= n_reached;
            r_pv      <= n_pv;
            r_cnt     <= n_cnt;
            r_found   <= n_found;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pi     <= n_pi;
        r_best   <= n_best;
        r_k      <= n_k;
        r_n      <= n_n;
        r_a      <= n_a;
        r_b      <= n_b;
        r_w      <= n_w;
        r_onode  <= n_onode;
        r_odist  <= n_odist;
        r_oreach <= n_oreach;
        r_opred  <= n_opred;
        r_olast  <= n_olast;
    end

    // Distance and predecessor memories with registered reads.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            dist_mem[mem_wr_idx] <= mem_wr_dist;
            pred_mem[mem_wr_idx] <= mem_wr_pred;
        end
        r_dist_q <= dist_mem[mem_rd_idx];
        r_pred_q <= pred_mem[mem_rd_idx];
    end

    // Configuration writes.
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= ddap_pkg::NODE_COUNT_RST;
            r_source     <= ddap_pkg::SOURCE_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                ddap_pkg::CFG_NODE_COUNT: r_node_count <= i_cfg.data;
                ddap_pkg::CFG_SOURCE:     r_source     <= i_cfg.data[NFW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Result channel.
    assign onode_ext          = {{NFW{1'b0}}, r_onode};
    assign opred_ext          = {{PFW{1'b0}}, r_opred};
    assign o_out.valid        = r_ovalid;
    assign o_out.node         = onode_ext[NFW-1:0];
    assign o_out.distance     = r_odist;
    assign o_out.reachable    = r_oreach;
    assign o_out.predecessors = opred_ext[PFW-1:0];
    assign o_out.last         = r_olast;

endmodule

FILE: sv/ddap_adj_ram.sv
// ----------------------------------------------------------------------------
// ddap_adj_ram: adjacency store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ddap_adj_ram #(
    parameter int AW = 12,
    parameter int DW = 17
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/ddap_alu.sv
// ----------------------------------------------------------------------------
// ddap_alu: shared add and compare unit
// Adds a weight to a distance with saturation and compares against a reference.
// ----------------------------------------------------------------------------
module ddap_alu #(
    parameter int WB = 16
) (
    input  logic [ddap_pkg::DIST_W-1:0] i_base,
    input  logic [WB-1:0]               i_addend,
    input  logic [ddap_pkg::DIST_W-1:0] i_cmp,
    output logic [ddap_pkg::DIST_W-1:0] o_sum,
    output logic                        o_lt,
    output logic                        o_eq
);

    localparam int DW = ddap_pkg::DIST_W;
    localparam int SW = ((WB > DW) ? WB : DW) + 1;

    logic [SW-1:0] sum_wide;

    // Saturating sum, then the compare against the reference.
    always_comb begin
        sum_wide = SW'(i_base) + SW'(i_addend);
        if (sum_wide > SW'(ddap_pkg::DIST_MAX)) begin
            o_sum = ddap_pkg::DIST_MAX;
        end else begin
            o_sum = sum_wide[DW-1:0];
        end
        o_lt = o_sum < i_cmp;
        o_eq = o_sum == i_cmp;
    end

endmodule
